// ----- hdl/pida_pkg.sv -----
// Shared types, constants and helpers of the process ID allocator.
package pida_pkg;

  // Default ID range size and reset base.
  localparam int unsigned IdCountDef  = 4701;
  localparam logic [15:0] BaseIdReset = 16'd300;

  // Bitmap words: 32 slots per word.
  localparam int unsigned WordBits = 32;
  localparam int unsigned BitIdxW  = 5;

  // Width that holds a slot count up to 65536.
  localparam int unsigned LimW = 17;

  typedef logic [15:0] id_t;

  typedef enum logic {
    FUNC_ALLOC   = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_RELEASED  = 2'd1,
    ST_NO_FREE   = 2'd2,
    ST_REJECTED  = 2'd3
  } status_e;

  typedef struct packed {
    func_e func;
    id_t   release_id;
  } req_t;

  typedef struct packed {
    status_e status;
    id_t     granted_id;
  } rsp_t;

  typedef struct packed {
    logic               found;
    logic [BitIdxW-1:0] idx;
  } zsearch_t;

  // Lowest clear bit of a bitmap word.
  function automatic zsearch_t first_zero(logic [WordBits-1:0] w);
    zsearch_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r.found = 1'b1;
        r.idx   = BitIdxW'(i);
      end
    end
    return r;
  endfunction

endpackage

// ----- hdl/pida_chan_if.sv -----
// Valid/ready channel carrying one word of type T.
interface pida_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/pida_bitmap_ram.sv -----
// Used-slot bitmap memory: one write port, one registered read port.
module pida_bitmap_ram
  import pida_pkg::*;
#(
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  logic [WordBits-1:0] wdata_i,
  input  logic                re_i,
  input  logic [AW-1:0]       raddr_i,
  output logic [WordBits-1:0] rdata_o
);

  logic [WordBits-1:0] mem [DEPTH];
  logic [WordBits-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/pida_ctrl.sv -----
// Sequencer: clears the bitmap, scans it for allocation and updates it on release.
module pida_ctrl
  import pida_pkg::*;
#(
  parameter int unsigned ID_COUNT = IdCountDef,
  localparam int unsigned WORDS   = (ID_COUNT + WordBits - 1) / WordBits,
  localparam int unsigned AW      = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  id_t                 base_i,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  req_t                req_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output rsp_t                res_o,
  output logic                mem_re_o,
  output logic [AW-1:0]       mem_raddr_o,
  input  logic [WordBits-1:0] mem_rdata_i,
  output logic                mem_we_o,
  output logic [AW-1:0]       mem_waddr_o,
  output logic [WordBits-1:0] mem_wdata_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_REL   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [LimW-1:0] IdCountL = LimW'(ID_COUNT);
  localparam logic [AW-1:0]   LastWord = AW'(WORDS - 1);

  logic [2:0]         state_q, state_d;
  logic [AW-1:0]      word_q, word_d;
  logic [BitIdxW-1:0] bit_q, bit_d;
  rsp_t               res_q, res_d;

  logic [LimW-1:0] room;
  logic [LimW-1:0] limit;
  id_t             id_diff;
  logic            rel_ok;
  zsearch_t        zs;
  logic [LimW-1:0] slot;
  logic [LimW-1:0] next_start;

  // Slots whose ID still fits in 16 bits.
  assign room  = 17'h10000 - {1'b0, base_i};
  assign limit = (room < IdCountL) ? room : IdCountL;

  assign id_diff = req_i.release_id - base_i;
  assign rel_ok  = (req_i.release_id >= base_i) && ({1'b0, id_diff} < limit);

  assign zs         = first_zero(mem_rdata_i);
  assign slot       = (LimW'(word_q) << BitIdxW) | LimW'(zs.idx);
  assign next_start = (LimW'(word_q) + LimW'(1)) << BitIdxW;

  always_comb begin
    state_d     = state_q;
    word_d      = word_q;
    bit_d       = bit_q;
    res_d       = res_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = word_q;
    mem_wdata_o = '0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we_o = 1'b1;
        if (word_q == LastWord) begin
          state_d = S_IDLE;
        end else begin
          word_d = word_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          if (req_i.func == FUNC_ALLOC) begin
            mem_re_o = 1'b1;
            word_d   = '0;
            state_d  = S_SCAN;
          end else if (rel_ok) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = AW'(id_diff >> BitIdxW);
            word_d      = AW'(id_diff >> BitIdxW);
            bit_d       = id_diff[BitIdxW-1:0];
            state_d     = S_REL;
          end else begin
            res_d   = '{status: ST_REJECTED, granted_id: '0};
            state_d = S_DONE;
          end
        end
      end
      S_SCAN: begin
        // Data of word_q is here; if it holds no free slot in range and more words remain, the next word is fetched.
        if (zs.found && (slot < limit)) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = mem_rdata_i | (WordBits'(1) << zs.idx);
          res_d       = '{status: ST_ALLOCATED, granted_id: base_i + slot[15:0]};
          state_d     = S_DONE;
        end else if (next_start >= limit) begin
          res_d   = '{status: ST_NO_FREE, granted_id: '0};
          state_d = S_DONE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = word_q + AW'(1);
          word_d      = word_q + AW'(1);
        end
      end
      S_REL: begin
        if (mem_rdata_i[bit_q]) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = mem_rdata_i & ~(WordBits'(1) << bit_q);
          res_d       = '{status: ST_RELEASED, granted_id: '0};
        end else begin
          res_d = '{status: ST_REJECTED, granted_id: '0};
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
        word_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      word_q  <= '0;
    end else begin
      state_q <= state_d;
      word_q  <= word_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q <= bit_d;
    res_q <= res_d;
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  // An allocation sets exactly one bit of the word it rewrites.
  a_alloc_sets_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && mem_we_o)
      |-> $countones(mem_wdata_o) == $countones(mem_rdata_i) + 1)
    else $error("allocation did not set exactly one bit");

  // A release clears exactly one bit of the word it rewrites.
  a_rel_clears_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REL && mem_we_o)
      |-> $countones(mem_rdata_i) == $countones(mem_wdata_o) + 1)
    else $error("release did not clear exactly one bit");

  // A bitmap write during a scan ends in a grant.
  a_write_grants: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && mem_we_o) |=> (res_q.status == ST_ALLOCATED))
    else $error("scan write without grant");

  // Only grants carry an ID.
  a_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_q.status != ST_ALLOCATED) |-> (res_q.granted_id == '0))
    else $error("non-grant result carries an ID");

  // Nothing is accepted while the clearing pass runs.
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !req_ready_o)
    else $error("request accepted during clearing pass");

endmodule

// ----- hdl/process_id_allocator_unit.sv -----
// Process ID allocator top level: base register, bitmap, sequencer and result register.
//
// Hands out the lowest free process ID of ID_COUNT consecutive IDs starting at
// base_id (fewer where they would pass ID 65535), and takes IDs back on release.
// Each request word on req_i gives one result word on rsp_o. After reset the
// bitmap is cleared one 32-slot word per cycle, all ceil(ID_COUNT/32) words (147
// at the default size), during which no request is taken; base_id writes are
// taken at any time. An allocation reads the bitmap one word per cycle from the
// bottom until it finds a free slot or reaches the end of the range. A release
// reads the word that holds its ID and clears that bit; an ID out of range or
// not in use is rejected. The result sits in an output register, so the next
// request is taken while it waits.
module process_id_allocator_unit
  import pida_pkg::*;
#(
  parameter int unsigned ID_COUNT = IdCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pida_chan_if.sink   cfg_i,
  pida_chan_if.sink   req_i,
  pida_chan_if.source rsp_o
);

  localparam int unsigned WORDS = (ID_COUNT + WordBits - 1) / WordBits;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  id_t  base_q;
  logic out_valid_q;
  rsp_t out_q;

  logic                res_valid;
  logic                res_ready;
  rsp_t                res;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [WordBits-1:0] mem_rdata;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [WordBits-1:0] mem_wdata;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BaseIdReset;
    end else if (cfg_i.valid) begin
      base_q <= cfg_i.data;
    end
  end

  // Output register frees when its word is taken.
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  pida_ctrl #(
    .ID_COUNT(ID_COUNT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .base_i      (base_q),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (req_i.data),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata)
  );

  pida_bitmap_ram #(
    .DEPTH(WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
